// ----- sv/pairwise_offset_histogram_macros.svh -----
// Assertion macros for the pairwise offset histogram
`ifndef PAIRWISE_OFFSET_HISTOGRAM_MACROS_SVH
`define PAIRWISE_OFFSET_HISTOGRAM_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define POH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define POH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/poh_pkg.sv -----
// Package: types, codes and defaults of the pairwise offset histogram
`timescale 1ns / 1ps
package poh_pkg;

  localparam int BINS_DEF       = 32;
  localparam int MAX_POINTS_DEF = 256;
  localparam logic [12:0] FRAME_RESET = 13'd200;

  // command codes
  localparam logic [1:0] FN_ADD   = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DROP  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // configuration register indexes
  localparam logic CFG_FRAME_W = 1'b0;
  localparam logic CFG_FRAME_H = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] point_x;
    logic [11:0] point_y;
    logic [4:0]  bin_row;
    logic [4:0]  bin_col;
  } in_word_t;

  typedef struct packed {
    logic [15:0] bin_value;
    logic [15:0] bin_count;
    logic [15:0] pair_total;
    logic [8:0]  points_held;
    logic [1:0]  status;
  } out_word_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_ADD,
    S_DRAIN,
    S_RD_WAIT,
    S_DIV,
    S_SQRT,
    S_DONE
  } state_t;

endpackage

// ----- sv/pairwise_offset_histogram.sv -----
// Top level: pairwise offset histogram with point store and bin count memory
//
// Use: commands enter as words on in_* (valid/ready); each command gives
// exactly one result word on out_* (valid/ready). Frame width and height are
// written on the cfg_* port (index 0 width, index 1 height); the user must
// write them only while idle, the block does not enforce it. Add point: the
// new point is paired with itself and every stored point; one pair enters
// the binning pipeline per cycle, fed by the point memory read port.
// Read bin: one memory read, a 48-step restoring divide, then a 24-step
// square root, both skipped when the total is zero. Clear: sweeps the bin
// memory. Other commands go straight to their result. Bin counts are
// updated by read-modify-write with forwarding of the last write, so
// adjacent pairs hitting the same bin count correctly. Reset: a clearing
// pass over all BINS*BINS entries (1024 at defaults) zeroes the bin memory;
// no command is taken during it, configuration writes still are.
// One command is worked at a time. The result sits in an output register;
// the next command is taken while it waits, and a stalled receiver holds
// the block only when the following result is ready to be written.
`timescale 1ns / 1ps
module pairwise_offset_histogram #(
  parameter int BINS       = poh_pkg::BINS_DEF,
  parameter int MAX_POINTS = poh_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  poh_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output poh_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [12:0]        cfg_data
);
  import poh_pkg::*;

  `include "pairwise_offset_histogram_macros.svh"

  localparam int QB  = $clog2(BINS);
  localparam int NW  = 14 + QB;
  localparam int NB  = BINS * BINS;
  localparam int AW  = $clog2(NB);
  localparam int PAW = $clog2(MAX_POINTS);
  localparam int TW  = $clog2(MAX_POINTS + 1);

  // state and control
  state_t state_r, state_nxt;
  logic [12:0] frame_w_r, frame_h_r;
  logic [15:0] total_r;
  logic [TW-1:0] tally_r;
  logic [TW-1:0] idx_r;
  logic [AW-1:0] clr_idx_r;
  logic clr_reply_r;
  logic self_r, ptv_r;
  logic [11:0] px_r, py_r;
  logic [5:0] step_r;
  logic out_valid_r;
  out_word_t out_word_r;

  // result holding
  logic [15:0] res_value_r, res_count_r;
  logic [1:0]  res_status_r;

  // divide / square root
  logic [16:0] rem_r;
  logic [47:0] dvd_r;
  logic [26:0] srem_r;
  logic [23:0] root_r;

  // memories
  logic [23:0] pt_mem [MAX_POINTS];
  logic [23:0] pt_rd_r;
  logic [15:0] bin_mem [NB];
  logic [15:0] bin_rd_r;

  logic accept, full, pipe_busy, out_load;
  logic [AW-1:0] bin_ra, bin_wa, rd_idx;
  logic bin_we;
  logic [15:0] bin_wd;
  logic [QB-1:0] rd_row, rd_col;

  assign accept   = in_valid && in_ready;
  assign full     = (tally_r == TW'(MAX_POINTS));
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // read bin index, clamped to the grid
  always_comb begin
    rd_row = (int'(in_word.bin_row) > BINS - 1) ? QB'(BINS - 1) : QB'(in_word.bin_row);
    rd_col = (int'(in_word.bin_col) > BINS - 1) ? QB'(BINS - 1) : QB'(in_word.bin_col);
    rd_idx = AW'(AW'(rd_row) * AW'(BINS) + AW'(rd_col));
  end

  // ---------------- binning pipeline ----------------
  logic feed_v;
  logic [11:0] fx, fy, ax, ay;
  logic [NW-1:0] dcx, dcy;

  assign feed_v = self_r || ptv_r;
  assign fx     = self_r ? px_r : pt_rd_r[23:12];
  assign fy     = self_r ? py_r : pt_rd_r[11:0];
  assign ax     = (px_r > fx) ? px_r - fx : fx - px_r;
  assign ay     = (py_r > fy) ? py_r - fy : fy - py_r;
  assign dcx    = NW'((frame_w_r == 13'd0) ? 13'd1 : frame_w_r);
  assign dcy    = NW'((frame_h_r == 13'd0) ? 13'd1 : frame_h_r);

  logic          sv_r   [0:QB];
  logic [NW-1:0] nx_r   [0:QB];
  logic [NW-1:0] ny_r   [0:QB];
  logic [QB-1:0] qx_r   [0:QB];
  logic [QB-1:0] qy_r   [0:QB];
  logic          satx_r [0:QB];
  logic          saty_r [0:QB];

  // stage 0: scale offsets, flag bins past the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else begin
      sv_r[0] <= feed_v;
    end
    nx_r[0]   <= NW'(ax) * NW'(2 * BINS);
    ny_r[0]   <= NW'(ay) * NW'(BINS);
    satx_r[0] <= (NW'(ax) * NW'(2 * BINS)) >= (NW'(BINS) * dcx);
    saty_r[0] <= (NW'(ay) * NW'(BINS)) >= (NW'(BINS) * dcy);
    qx_r[0]   <= '0;
    qy_r[0]   <= '0;
  end

  // stages 1..QB: one quotient bit per stage, MSB first
  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [NW-1:0] tx, ty;
    assign tx = dcx << (QB - k);
    assign ty = dcy << (QB - k);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else begin
        sv_r[k] <= sv_r[k-1];
      end
      satx_r[k] <= satx_r[k-1];
      saty_r[k] <= saty_r[k-1];
      if (nx_r[k-1] >= tx) begin
        nx_r[k] <= nx_r[k-1] - tx;
        qx_r[k] <= qx_r[k-1] | (QB'(1) << (QB - k));
      end else begin
        nx_r[k] <= nx_r[k-1];
        qx_r[k] <= qx_r[k-1];
      end
      if (ny_r[k-1] >= ty) begin
        ny_r[k] <= ny_r[k-1] - ty;
        qy_r[k] <= qy_r[k-1] | (QB'(1) << (QB - k));
      end else begin
        ny_r[k] <= ny_r[k-1];
        qy_r[k] <= qy_r[k-1];
      end
    end
  end

  // bin address stage
  logic [QB-1:0] colq, rowq;
  logic a_v_r, b_v_r;
  logic [AW-1:0] a_addr_r, b_addr_r;
  assign colq = satx_r[QB] ? QB'(BINS - 1) : qx_r[QB];
  assign rowq = saty_r[QB] ? QB'(BINS - 1) : qy_r[QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= sv_r[QB];
      b_v_r <= a_v_r;
    end
    a_addr_r <= AW'(AW'(rowq) * AW'(BINS) + AW'(colq));
    b_addr_r <= a_addr_r;
  end

  // read-modify-write with forwarding of the write made at the read edge
  logic wl_v_r;
  logic [AW-1:0] wl_a_r;
  logic [15:0] wl_d_r, cur, inc;
  assign cur = (wl_v_r && (wl_a_r == b_addr_r)) ? wl_d_r : bin_rd_r;
  assign inc = (cur == 16'hFFFF) ? cur : cur + 16'd1;

  // any pair still anywhere in the pipeline
  always_comb begin
    pipe_busy = a_v_r || b_v_r || self_r || ptv_r;
    for (int k = 0; k <= QB; k++) begin
      pipe_busy = pipe_busy || sv_r[k];
    end
  end

  // bin memory port selection
  always_comb begin
    bin_ra = (state_r == S_IDLE) ? rd_idx : a_addr_r;
    if (state_r == S_CLR) begin
      bin_we = 1'b1;
      bin_wa = clr_idx_r;
      bin_wd = 16'd0;
    end else begin
      bin_we = b_v_r;
      bin_wa = b_addr_r;
      bin_wd = inc;
    end
  end

  // bin count memory
  always_ff @(posedge clk) begin
    bin_rd_r <= bin_mem[bin_ra];
    if (bin_we) begin
      bin_mem[bin_wa] <= bin_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_v_r <= 1'b0;
    end else begin
      wl_v_r <= bin_we;
    end
    wl_a_r <= bin_wa;
    wl_d_r <= bin_wd;
  end

  // point store
  logic pt_we;
  assign pt_we = (state_r == S_ADD) && (idx_r == tally_r);

  always_ff @(posedge clk) begin
    pt_rd_r <= pt_mem[idx_r[PAW-1:0]];
    if (pt_we) begin
      pt_mem[tally_r[PAW-1:0]] <= {px_r, py_r};
    end
  end

  // ---------------- sequencer ----------------
  logic [16:0] rem_sh;
  logic [26:0] srem_sh, strial;
  assign rem_sh  = {rem_r[15:0], dvd_r[47]};
  assign srem_sh = {srem_r[24:0], dvd_r[47:46]};
  assign strial  = {1'b0, root_r, 2'b01};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (clr_idx_r == AW'(NB - 1)) begin
          state_nxt = clr_reply_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_word.func)
            FN_ADD:   state_nxt = full ? S_DONE : S_ADD;
            FN_READ:  state_nxt = S_RD_WAIT;
            FN_CLEAR: state_nxt = S_CLR;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_ADD:     if (idx_r == tally_r) state_nxt = S_DRAIN;
      S_DRAIN:   if (!pipe_busy) state_nxt = S_DONE;
      S_RD_WAIT: state_nxt = (total_r == 16'd0) ? S_DONE : S_DIV;
      S_DIV:     if (step_r == 6'd47) state_nxt = S_SQRT;
      S_SQRT:    if (step_r == 6'd23) state_nxt = S_DONE;
      S_DONE:    if (out_load) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    out_valid = out_valid_r;
    out_word  = out_word_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      clr_reply_r <= 1'b0;
      total_r     <= '0;
      tally_r     <= '0;
      self_r      <= 1'b0;
      ptv_r       <= 1'b0;
      out_valid_r <= 1'b0;
      frame_w_r   <= FRAME_RESET;
      frame_h_r   <= FRAME_RESET;
      idx_r       <= '0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_FRAME_W) frame_w_r <= cfg_data;
        else                          frame_h_r <= cfg_data;
      end
      self_r <= accept && (in_word.func == FN_ADD) && !full;
      ptv_r  <= (state_r == S_ADD) && (idx_r != tally_r);
      if (state_r == S_CLR) clr_idx_r <= clr_idx_r + AW'(1);
      if (accept && in_word.func == FN_CLEAR) begin
        clr_idx_r   <= '0;
        clr_reply_r <= 1'b1;
        total_r     <= '0;
        tally_r     <= '0;
      end
      if (accept) idx_r <= '0;
      if (state_r == S_ADD && idx_r != tally_r) idx_r <= idx_r + TW'(1);
      if (pt_we) tally_r <= tally_r + TW'(1);
      if (b_v_r && total_r != 16'hFFFF) total_r <= total_r + 16'd1;
      if (state_r == S_RD_WAIT || (state_r == S_DIV && step_r == 6'd47)) begin
        step_r <= '0;
      end else if (state_r == S_DIV || state_r == S_SQRT) begin
        step_r <= step_r + 6'd1;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // command data, divider, square root and result
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r         <= in_word.point_x;
      py_r         <= in_word.point_y;
      res_value_r  <= '0;
      res_count_r  <= '0;
      res_status_r <= (in_word.func == FN_ADD && full) ? ST_DROP : ST_OK;
    end
    unique case (state_r)
      S_RD_WAIT: begin
        res_count_r <= bin_rd_r;
        dvd_r       <= {bin_rd_r, 32'd0};
        rem_r       <= '0;
        srem_r      <= '0;
        root_r      <= '0;
        if (total_r == 16'd0) res_status_r <= ST_EMPTY;
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, total_r}) begin
          rem_r <= rem_sh - {1'b0, total_r};
          dvd_r <= {dvd_r[46:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          dvd_r <= {dvd_r[46:0], 1'b0};
        end
      end
      S_SQRT: begin
        dvd_r <= {dvd_r[45:0], 2'b00};
        if (srem_sh >= strial) begin
          srem_r <= srem_sh - strial;
          root_r <= {root_r[22:0], 1'b1};
        end else begin
          srem_r <= srem_sh;
          root_r <= {root_r[22:0], 1'b0};
        end
        if (step_r == 6'd23) begin
          res_value_r <= 16'hFFFF;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_word_r.bin_value   <= res_value_r == 16'hFFFF && root_r[23:16] == 8'd0
                                ? root_r[15:0] : res_value_r;
      out_word_r.bin_count   <= res_count_r;
      out_word_r.pair_total  <= total_r;
      out_word_r.points_held <= 9'(tally_r);
      out_word_r.status      <= res_status_r;
    end
  end

  // checks
  `POH_ASSERT_NOW(a_idle_empty, in_ready, !pipe_busy, "command taken while pairs in flight")
  `POH_ASSERT_NOW(a_tally_cap, 1'b1, tally_r <= TW'(MAX_POINTS), "point count past capacity")
  `POH_ASSERT_NOW(a_div_total, state_r == S_DIV, total_r != 16'd0, "divide by zero total")

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench: pairwise offset histogram checked against a built-in predictor
`timescale 1ns / 1ps
module testbench;
  import poh_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_word_t   in_word;
  logic       out_valid;
  logic       out_ready;
  out_word_t  out_word;
  logic       cfg_we;
  logic       cfg_index;
  logic [12:0] cfg_data;

  pairwise_offset_histogram dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // histogram predictor state
  logic [15:0] hist_bins [BINS_DEF*BINS_DEF];
  logic [11:0] pts_x [MAX_POINTS_DEF];
  logic [11:0] pts_y [MAX_POINTS_DEF];
  logic [15:0] pairs_seen;
  int unsigned point_count;
  logic [12:0] frame_w;
  logic [12:0] frame_h;

  out_word_t   pending_results[$];
  int          fail_count;
  int          words_sent;
  bit          no_idle;
  int          recv_gap;
  int          hold_cnt;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #32_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // bin index of one offset
  function automatic int unsigned offset_bin(int unsigned off, int unsigned scale,
                                             logic [12:0] div);
    int unsigned d;
    int unsigned q;
    d = (div == 0) ? 1 : div;
    q = (off * scale) / d;
    return (q > BINS_DEF - 1) ? BINS_DEF - 1 : q;
  endfunction

  function automatic void count_pair(int unsigned x0, int unsigned y0,
                                     int unsigned x1, int unsigned y1);
    int unsigned col;
    int unsigned row;
    col = offset_bin((x0 > x1) ? x0 - x1 : x1 - x0, 2 * BINS_DEF, frame_w);
    row = offset_bin((y0 > y1) ? y0 - y1 : y1 - y0, BINS_DEF, frame_h);
    if (hist_bins[row*BINS_DEF + col] != 16'hFFFF)
      hist_bins[row*BINS_DEF + col]++;
    if (pairs_seen != 16'hFFFF)
      pairs_seen++;
  endfunction

  // floor of the square root, result fits in 25 bits here
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 26; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v)
        r = t;
    end
    return r;
  endfunction

  // advance the histogram by one command word, return its result
  function automatic out_word_t histogram_step(in_word_t w);
    out_word_t   r;
    logic [63:0] q;
    logic [63:0] s;
    r = '0;
    case (w.func)
      FN_ADD: begin
        if (point_count >= MAX_POINTS_DEF) begin
          r.status = ST_DROP;
        end else begin
          count_pair(w.point_x, w.point_y, w.point_x, w.point_y);
          for (int i = 0; i < point_count; i++)
            count_pair(w.point_x, w.point_y, pts_x[i], pts_y[i]);
          pts_x[point_count] = w.point_x;
          pts_y[point_count] = w.point_y;
          point_count++;
        end
      end
      FN_READ: begin
        r.bin_count = hist_bins[w.bin_row*BINS_DEF + w.bin_col];
        if (pairs_seen == 0) begin
          r.status = ST_EMPTY;
        end else begin
          q = {16'd0, r.bin_count, 32'd0} / {48'd0, pairs_seen};
          s = floor_sqrt(q);
          r.bin_value = (s > 64'hFFFF) ? 16'hFFFF : s[15:0];
        end
      end
      FN_CLEAR: begin
        foreach (hist_bins[i]) hist_bins[i] = '0;
        pairs_seen = '0;
        point_count = 0;
      end
      default: ;
    endcase
    r.pair_total = pairs_seen;
    r.points_held = point_count[8:0];
    return r;
  endfunction

  // send one word; returns at the edge that accepts it
  task automatic send_word(in_word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(histogram_step(w));
    words_sent++;
  endtask

  task automatic send_cmd(logic [1:0] f, int x, int y, int row, int col);
    in_word_t w;
    w.func = f;
    w.point_x = x;
    w.point_y = y;
    w.bin_row = row;
    w.bin_col = col;
    send_word(w);
  endtask

  // drop valid and let every result come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // register write, only while idle
  task automatic cfg_write(logic idx, logic [12:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_W) frame_w = val;
    else frame_h = val;
  endtask

  // result receiver: per-word stall, long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        out_ready <= 1'b0;
        hold_cnt--;
      end else if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, int unsigned exp, int unsigned got);
    if (exp != got) begin
      $display("%0t: %s mismatch expected %0d actual %0d", $realtime, name, exp, got);
      fail_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_word_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, out_word);
        fail_count++;
      end else begin
        exp = pending_results.pop_front();
        check_field("bin_value", exp.bin_value, out_word.bin_value);
        check_field("bin_count", exp.bin_count, out_word.bin_count);
        check_field("pair_total", exp.pair_total, out_word.pair_total);
        check_field("points_held", exp.points_held, out_word.points_held);
        check_field("status", exp.status, out_word.status);
      end
      recv_gap = no_idle ? 0 : $urandom_range(0, 3);
    end
  end

  // empty reads, unused command, first points at field extremes
  task automatic test_directed();
    send_cmd(FN_READ, 0, 0, 0, 0);
    send_cmd(FN_READ, 4095, 4095, 31, 31);
    send_cmd(2'd3, 4095, 4095, 31, 31);
    send_cmd(FN_ADD, 0, 0, 31, 31);
    send_cmd(FN_READ, 0, 0, 0, 0);           // count equals total, saturates
    send_cmd(FN_ADD, 4095, 4095, 0, 0);
    send_cmd(FN_ADD, 4095, 0, 0, 0);
    send_cmd(FN_ADD, 0, 4095, 0, 0);
    send_cmd(FN_READ, 0, 0, 31, 31);
    send_cmd(FN_READ, 0, 0, 0, 0);
    send_cmd(FN_READ, 0, 0, 0, 31);
    send_cmd(FN_READ, 0, 0, 31, 0);
    send_cmd(FN_ADD, 100, 50, 0, 0);
    send_cmd(FN_READ, 0, 0, 15, 16);
    send_cmd(2'd3, 0, 0, 0, 0);
    send_cmd(FN_CLEAR, 0, 0, 0, 0);
    send_cmd(FN_READ, 0, 0, 0, 0);
  endtask

  // frame registers at their extremes, zero used as one
  task automatic test_frame_regs();
    logic [12:0] vals [5] = '{13'd0, 13'd1, 13'd4096, 13'd8191, 13'd37};
    foreach (vals[i]) begin
      cfg_write(CFG_FRAME_W, vals[i]);
      cfg_write(CFG_FRAME_H, vals[4-i]);
      send_cmd(FN_CLEAR, 0, 0, 0, 0);
      for (int k = 0; k < 4; k++)
        send_cmd(FN_ADD, $urandom_range(0, 4095), $urandom_range(0, 4095), 0, 0);
      send_cmd(FN_ADD, 0, 1, 0, 0);
      send_cmd(FN_ADD, 1, 0, 0, 0);
      send_cmd(FN_READ, 0, 0, 0, 0);
      send_cmd(FN_READ, 0, 0, 31, 31);
    end
    cfg_write(CFG_FRAME_W, FRAME_RESET);
    cfg_write(CFG_FRAME_H, FRAME_RESET);
  endtask

  // fill the point store past capacity
  task automatic test_store_full();
    send_cmd(FN_CLEAR, 0, 0, 0, 0);
    for (int k = 0; k < MAX_POINTS_DEF + 3; k++)
      send_cmd(FN_ADD, $urandom_range(0, 300), $urandom_range(0, 300), 0, 0);
    for (int k = 0; k < 6; k++)
      send_cmd(FN_READ, 0, 0, $urandom_range(0, 4), $urandom_range(0, 4));
  endtask

  // long receiver stall while words keep coming
  task automatic test_backpressure();
    hold_cnt = 600;
    for (int k = 0; k < 12; k++)
      send_cmd(k % 3 == 0 ? FN_READ : FN_ADD, $urandom_range(0, 4095),
               $urandom_range(0, 4095), $urandom_range(0, 31), $urandom_range(0, 31));
  endtask

  // random contours: usually a clear, a run of points, then reads, with some noise
  task automatic test_random();
    int npts;
    int cx;
    int cy;
    int spread;
    while (words_sent < 1350) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0)
        cfg_write($urandom_range(0, 1), $urandom_range(0, 8191));
      if ($urandom_range(0, 3) != 0)
        send_cmd(FN_CLEAR, $urandom, $urandom, $urandom, $urandom);
      npts = ($urandom_range(0, 14) == 0) ? $urandom_range(240, 262)
                                           : $urandom_range(1, 30);
      cx = $urandom_range(0, 4095);
      cy = $urandom_range(0, 4095);
      spread = 1 << $urandom_range(2, 12);
      for (int k = 0; k < npts; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_cmd($urandom_range(1, 3), $urandom, $urandom, $urandom, $urandom);
        else
          send_cmd(FN_ADD, (cx + $urandom_range(0, spread - 1)) % 4096,
                   (cy + $urandom_range(0, spread - 1)) % 4096, $urandom, $urandom);
      end
      for (int k = $urandom_range(2, 12); k > 0; k--) begin
        if ($urandom_range(0, 1) == 0)
          send_cmd(FN_READ, $urandom, $urandom, $urandom_range(0, 31),
                   $urandom_range(0, 31));
        else
          send_cmd(FN_READ, $urandom, $urandom, $urandom_range(0, 6),
                   $urandom_range(0, 6));
      end
    end
    no_idle = 0;
  endtask

  // main sequence
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAME_W;
    cfg_data = '0;
    fail_count = 0;
    words_sent = 0;
    no_idle = 0;
    recv_gap = 0;
    hold_cnt = 0;
    frame_w = FRAME_RESET;
    frame_h = FRAME_RESET;
    pairs_seen = '0;
    point_count = 0;
    foreach (hist_bins[i]) hist_bins[i] = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_frame_regs();
    test_store_full();
    test_backpressure();
    test_random();

    drain();
    repeat (100) @(negedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
